>>> design/dsft_pkg.sv
// ----------------------------------------------------------------------------
// dsft_pkg
// shared types, constants and helpers for the dual sensor fusion thermostat
// ----------------------------------------------------------------------------
package dsft_pkg;

  // field widths
  localparam int TEMP_IN_W  = 11;  // signed tenths of a degree
  localparam int HUM_W      = 10;  // tenths of a percent
  localparam int TEMP_OUT_W = 10;  // fused temperature, tenths
  localparam int TARGET_W   = 6;
  localparam int FAIL_W     = 8;
  localparam int TGAP_W     = 5;
  localparam int HGAP_W     = 7;
  localparam int GAP_CMP_W  = 12;  // width for gap magnitudes and thresholds

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // register reset values
  localparam logic [TARGET_W-1:0] TARGET_RST   = 6'd36;
  localparam logic [FAIL_W-1:0]   FAIL_LIM_RST = 8'd10;
  localparam logic [TGAP_W-1:0]   TGAP_RST     = 5'd3;
  localparam logic [HGAP_W-1:0]   HGAP_RST     = 7'd10;

  localparam logic [FAIL_W-1:0]   FAIL_CNT_MAX = 8'd255;

  // register index, byte address divided by four
  typedef enum logic [1:0] {
    REG_TARGET_TEMP    = 2'd0,
    REG_FAIL_LIMIT     = 2'd1,
    REG_TEMP_GAP_LIMIT = 2'd2,
    REG_HUM_GAP_LIMIT  = 2'd3
  } reg_idx_t;

  // sensor status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_READ_FAIL = 2'd1,
    STAT_DISAGREE  = 2'd2
  } status_t;

  // one paired reading as held in the input register
  typedef struct packed {
    logic                        first_ok;
    logic signed [TEMP_IN_W-1:0] first_temp;
    logic [HUM_W-1:0]            first_hum;
    logic                        second_ok;
    logic signed [TEMP_IN_W-1:0] second_temp;
    logic [HUM_W-1:0]            second_hum;
  } sample_t;

  // one fused result as held in the output register
  typedef struct packed {
    logic [TEMP_OUT_W-1:0] fused_temp;
    logic                  temp_valid;
    status_t               temp_status;
    logic [HUM_W-1:0]      fused_hum;
    logic                  hum_valid;
    status_t               hum_status;
    logic                  heat_on;
  } result_t;

  // smallest magnitude (tenths) whose whole-unit truncation exceeds lim
  function automatic logic [GAP_CMP_W-1:0] gap_thresh(input logic [HGAP_W-1:0] lim);
    logic [GAP_CMP_W-1:0] lp1;
    lp1 = {{(GAP_CMP_W-HGAP_W){1'b0}}, lim} + 12'd1;
    return (lp1 << 3) + (lp1 << 1);
  endfunction

endpackage

>>> design/dsft_in_if.sv
// ----------------------------------------------------------------------------
// dsft_in_if
// valid/ready channel carrying one paired sensor reading
// ----------------------------------------------------------------------------
interface dsft_in_if;
  import dsft_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        first_ok;
  logic signed [TEMP_IN_W-1:0] first_temp;
  logic [HUM_W-1:0]            first_hum;
  logic                        second_ok;
  logic signed [TEMP_IN_W-1:0] second_temp;
  logic [HUM_W-1:0]            second_hum;

  modport source (
    output valid, first_ok, first_temp, first_hum, second_ok, second_temp, second_hum,
    input  ready
  );

  modport sink (
    input  valid, first_ok, first_temp, first_hum, second_ok, second_temp, second_hum,
    output ready
  );
endinterface

>>> design/dsft_out_if.sv
// ----------------------------------------------------------------------------
// dsft_out_if
// valid/ready channel carrying one fused result
// ----------------------------------------------------------------------------
interface dsft_out_if;
  import dsft_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [TEMP_OUT_W-1:0] fused_temp;
  logic                  temp_valid;
  logic [1:0]            temp_status;
  logic [HUM_W-1:0]      fused_hum;
  logic                  hum_valid;
  logic [1:0]            hum_status;
  logic                  heat_on;

  modport source (
    output valid, fused_temp, temp_valid, temp_status, fused_hum, hum_valid, hum_status,
           heat_on,
    input  ready
  );

  modport sink (
    input  valid, fused_temp, temp_valid, temp_status, fused_hum, hum_valid, hum_status,
           heat_on,
    output ready
  );
endinterface

>>> design/dual_sensor_fusion_thermostat.sv
// ----------------------------------------------------------------------------
// dual_sensor_fusion_thermostat
// fuses two redundant temperature/humidity sensors and decides on heating
// ----------------------------------------------------------------------------
// Each transfer on in_ch is one paired reading from two sensors; each yields
// exactly one transfer on out_ch, in order. A reading goes into an input
// register, and the fusion logic (averages, disagreement compares,
// held-temperature bookkeeping and heater compare) runs between that
// register and the output register; out_ch.valid rises once the fused
// result is loaded there, and one reading is taken every cycle when
// out_ch.ready stays high. A stalled output keeps its result while one more
// reading waits in the input register; in_ch.ready drops only when both are
// full and the output is not being taken. Configuration registers are read
// and written over the cfg_ APB port (target_temp at 0x0, fail_limit at 0x4,
// temp_gap_limit at 0x8, hum_gap_limit at 0xC) and should be written while
// no reading is in flight.
// ----------------------------------------------------------------------------
module dual_sensor_fusion_thermostat (
  input  logic                          clk,
  input  logic                          rst_n,
  dsft_in_if.sink                       in_ch,
  dsft_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dsft_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [dsft_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [dsft_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import dsft_pkg::*;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [TARGET_W-1:0] target_r;
  logic [FAIL_W-1:0]   fail_lim_r;
  logic [TGAP_W-1:0]   tgap_r;
  logic [HGAP_W-1:0]   hgap_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  // low address bits are ignored, registers sit on word boundaries
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= TARGET_RST;
      fail_lim_r <= FAIL_LIM_RST;
      tgap_r     <= TGAP_RST;
      hgap_r     <= HGAP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TARGET_TEMP:    target_r   <= cfg_pwdata[TARGET_W-1:0];
        REG_FAIL_LIMIT:     fail_lim_r <= cfg_pwdata[FAIL_W-1:0];
        REG_TEMP_GAP_LIMIT: tgap_r     <= cfg_pwdata[TGAP_W-1:0];
        REG_HUM_GAP_LIMIT:  hgap_r     <= cfg_pwdata[HGAP_W-1:0];
      endcase
    end
  end

  // read data, zero extended
  always_comb begin
    unique case (cfg_idx)
      REG_TARGET_TEMP:    cfg_prdata = {{(CFG_DATA_W-TARGET_W){1'b0}}, target_r};
      REG_FAIL_LIMIT:     cfg_prdata = {{(CFG_DATA_W-FAIL_W){1'b0}}, fail_lim_r};
      REG_TEMP_GAP_LIMIT: cfg_prdata = {{(CFG_DATA_W-TGAP_W){1'b0}}, tgap_r};
      REG_HUM_GAP_LIMIT:  cfg_prdata = {{(CFG_DATA_W-HGAP_W){1'b0}}, hgap_r};
    endcase
  end

  // --------------------------------------------------------------------------
  // handshake: input register feeds output register
  // --------------------------------------------------------------------------
  logic    s1_valid_r;
  sample_t s1_r;
  logic    out_valid_r;
  result_t out_r;
  logic    out_adv;   // output register can load this cycle
  logic    s2_fire;   // reading in the input register moves to the output
  logic    in_xfer;

  assign out_adv      = !out_valid_r || out_ch.ready;
  assign s2_fire      = s1_valid_r && out_adv;
  // room in the input register when empty or being drained this cycle
  assign in_ch.ready  = !s1_valid_r || out_adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r.first_ok    <= in_ch.first_ok;
      s1_r.first_temp  <= in_ch.first_temp;
      s1_r.first_hum   <= in_ch.first_hum;
      s1_r.second_ok   <= in_ch.second_ok;
      s1_r.second_temp <= in_ch.second_temp;
      s1_r.second_hum  <= in_ch.second_hum;
    end
  end

  // --------------------------------------------------------------------------
  // fusion logic
  // --------------------------------------------------------------------------
  logic                  held_valid_r, held_valid_nxt;
  logic [TEMP_OUT_W-1:0] held_temp_r, held_temp_nxt;
  logic [FAIL_W-1:0]     fail_cnt_r, fail_cnt_nxt;

  logic                  ut1, ut2, both_ok;
  logic [TEMP_OUT_W:0]   t_sum;
  logic [HUM_W:0]        h_sum;
  logic signed [GAP_CMP_W-1:0] t_diff, h_diff;
  logic [GAP_CMP_W-1:0]  t_mag, h_mag;
  logic [GAP_CMP_W-1:0]  t_thr, h_thr;
  logic [TEMP_OUT_W-1:0] target_x10;
  result_t               res;

  // a failed read or a negative temperature is a missing reading
  assign ut1     = s1_r.first_ok  && !s1_r.first_temp[TEMP_IN_W-1];
  assign ut2     = s1_r.second_ok && !s1_r.second_temp[TEMP_IN_W-1];
  assign both_ok = s1_r.first_ok && s1_r.second_ok;

  // usable temperatures are non-negative, so their low bits are the value
  assign t_sum = {1'b0, s1_r.first_temp[TEMP_OUT_W-1:0]}
               + {1'b0, s1_r.second_temp[TEMP_OUT_W-1:0]};
  assign h_sum = {1'b0, s1_r.first_hum} + {1'b0, s1_r.second_hum};

  // held temperature and consecutive double-failure count
  always_comb begin
    held_temp_nxt  = held_temp_r;
    held_valid_nxt = held_valid_r;
    fail_cnt_nxt   = fail_cnt_r;
    if (!ut1 && !ut2) begin
      fail_cnt_nxt = (fail_cnt_r == FAIL_CNT_MAX) ? fail_cnt_r : fail_cnt_r + 8'd1;
      if (fail_cnt_nxt > fail_lim_r) begin
        held_valid_nxt = 1'b0;
      end
    end else begin
      priority if (!ut1) begin
        held_temp_nxt = s1_r.second_temp[TEMP_OUT_W-1:0];
      end else if (!ut2) begin
        held_temp_nxt = s1_r.first_temp[TEMP_OUT_W-1:0];
      end else begin
        held_temp_nxt = t_sum[TEMP_OUT_W:1];
      end
      held_valid_nxt = 1'b1;
      fail_cnt_nxt   = '0;
    end
  end

  // disagreement: |diff|/10 > lim  is the same as  |diff| >= 10*(lim+1)
  assign t_diff = GAP_CMP_W'(s1_r.first_temp) - GAP_CMP_W'(s1_r.second_temp);
  assign h_diff = $signed({{(GAP_CMP_W-HUM_W){1'b0}}, s1_r.first_hum})
                - $signed({{(GAP_CMP_W-HUM_W){1'b0}}, s1_r.second_hum});
  assign t_mag  = t_diff[GAP_CMP_W-1] ? GAP_CMP_W'(-t_diff) : GAP_CMP_W'(t_diff);
  assign h_mag  = h_diff[GAP_CMP_W-1] ? GAP_CMP_W'(-h_diff) : GAP_CMP_W'(h_diff);
  assign t_thr  = gap_thresh({{(HGAP_W-TGAP_W){1'b0}}, tgap_r});
  assign h_thr  = gap_thresh(hgap_r);

  // target in tenths, at most 630
  assign target_x10 = TEMP_OUT_W'({target_r, 3'b000}) + TEMP_OUT_W'({target_r, 1'b0});

  always_comb begin
    res.temp_valid = held_valid_nxt;
    res.fused_temp = held_valid_nxt ? held_temp_nxt : '0;
    res.heat_on    = held_valid_nxt && (target_x10 > held_temp_nxt);

    priority if (both_ok) begin
      res.fused_hum = h_sum[HUM_W:1];
      res.hum_valid = 1'b1;
    end else if (s1_r.first_ok) begin
      res.fused_hum = s1_r.first_hum;
      res.hum_valid = 1'b1;
    end else if (s1_r.second_ok) begin
      res.fused_hum = s1_r.second_hum;
      res.hum_valid = 1'b1;
    end else begin
      res.fused_hum = '0;
      res.hum_valid = 1'b0;
    end

    if (both_ok) begin
      res.temp_status = (t_mag >= t_thr) ? STAT_DISAGREE : STAT_OK;
      res.hum_status  = (h_mag >= h_thr) ? STAT_DISAGREE : STAT_OK;
    end else begin
      res.temp_status = STAT_READ_FAIL;
      res.hum_status  = STAT_READ_FAIL;
    end
  end

  // state advances only when a reading is actually fused
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_temp_r  <= '0;
      held_valid_r <= 1'b1;
      fail_cnt_r   <= '0;
    end else if (s2_fire) begin
      held_temp_r  <= held_temp_nxt;
      held_valid_r <= held_valid_nxt;
      fail_cnt_r   <= fail_cnt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.fused_temp  = out_r.fused_temp;
  assign out_ch.temp_valid  = out_r.temp_valid;
  assign out_ch.temp_status = out_r.temp_status;
  assign out_ch.fused_hum   = out_r.fused_hum;
  assign out_ch.hum_valid   = out_r.hum_valid;
  assign out_ch.hum_status  = out_r.hum_status;
  assign out_ch.heat_on     = out_r.heat_on;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // an invalid temperature reads as zero and never heats
  a_invalid_temp_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.temp_valid) |-> (out_r.fused_temp == '0 && !out_r.heat_on))
    else $error("invalid temperature with nonzero value or heating");

  // held temperature is only dropped after at least one double failure
  a_invalid_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    !held_valid_r |-> (fail_cnt_r != '0))
    else $error("held temperature invalid with zero failure count");

  // a usable temperature clears the failure count
  a_usable_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && (ut1 || ut2)) |=> (fail_cnt_r == '0 && held_valid_r))
    else $error("failure count not cleared by usable reading");

  // read failure is reported on both channels together
  a_fail_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.temp_status == STAT_READ_FAIL)
                     == (out_r.hum_status == STAT_READ_FAIL)))
    else $error("read failure status differs between temperature and humidity");

  // input stalls only with a full input register and a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without cause");

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the dual sensor fusion thermostat
// ----------------------------------------------------------------------------
// Paired sensor readings go out on in_ch from a queue, with random gaps. Each
// accepted reading runs through a local model of the fusion rules, and the
// model's result is queued. Every result taken from out_ch is checked field by
// field against the oldest queued result. Register writes over the cfg_ port
// happen only with nothing in flight, and each write is read back.
// ----------------------------------------------------------------------------
module tb;
  import dsft_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  dsft_in_if  in_ch ();
  dsft_out_if out_ch ();

  dual_sensor_fusion_thermostat uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // readings waiting to be sent, and fused results still owed by the block
  sample_t reading_q[$];
  result_t fused_q[$];
  sample_t offered;
  result_t mon_want;
  int      err_cnt = 0;

  // idle odds in percent, changed by the main sequence between phases
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // long receiver hold-off: main sequence bumps stall_reqs, stall counter serves it
  int stall_reqs   = 0;
  int stall_served = 0;
  int stall_left   = 0;

  // local copy of the registers
  logic [TARGET_W-1:0] tgt;
  logic [FAIL_W-1:0]   lim_fail;
  logic [TGAP_W-1:0]   lim_tgap;
  logic [HGAP_W-1:0]   lim_hgap;

  // local copy of the block's temperature bookkeeping
  logic [TEMP_OUT_W-1:0] held;
  logic                  held_ok;
  logic [FAIL_W-1:0]     fail_cnt;

  // whole-unit truncated gap above limit
  function automatic bit gap_over(int a, int b, int lim);
    int d;
    d = a - b;
    if (d < 0) d = -d;
    return (d / 10) > lim;
  endfunction

  // fusion rules for one reading; updates the held-temperature state
  function automatic result_t fuse_reading(sample_t s);
    result_t          r;
    logic             use1, use2, both_ok;
    logic [11:0]      tsum;
    logic [HUM_W:0]   hsum;
    int               t1, t2;
    t1      = $signed(s.first_temp);
    t2      = $signed(s.second_temp);
    use1    = s.first_ok && !s.first_temp[TEMP_IN_W-1];
    use2    = s.second_ok && !s.second_temp[TEMP_IN_W-1];
    both_ok = s.first_ok && s.second_ok;

    if (!use1 && !use2) begin
      // double failure: count it, drop validity once past the limit
      if (fail_cnt != FAIL_CNT_MAX) fail_cnt = fail_cnt + 1'b1;
      if (fail_cnt > lim_fail) held_ok = 1'b0;
    end else begin
      tsum = {1'b0, s.first_temp} + {1'b0, s.second_temp};
      if (!use1)      held = s.second_temp[TEMP_OUT_W-1:0];
      else if (!use2) held = s.first_temp[TEMP_OUT_W-1:0];
      else            held = tsum[TEMP_OUT_W:1];
      held_ok  = 1'b1;
      fail_cnt = '0;
    end

    hsum = {1'b0, s.first_hum} + {1'b0, s.second_hum};
    r.hum_valid = s.first_ok || s.second_ok;
    if (both_ok)          r.fused_hum = hsum[HUM_W:1];
    else if (s.first_ok)  r.fused_hum = s.first_hum;
    else if (s.second_ok) r.fused_hum = s.second_hum;
    else                  r.fused_hum = '0;

    if (both_ok) begin
      r.temp_status = gap_over(t1, t2, lim_tgap) ? STAT_DISAGREE : STAT_OK;
      r.hum_status  = gap_over(s.first_hum, s.second_hum, lim_hgap) ? STAT_DISAGREE : STAT_OK;
    end else begin
      r.temp_status = STAT_READ_FAIL;
      r.hum_status  = STAT_READ_FAIL;
    end

    r.temp_valid = held_ok;
    r.fused_temp = held_ok ? held : '0;
    r.heat_on    = held_ok && (int'(tgt) * 10 > int'(held));
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers the next queued reading once the previous one is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      // transfer on in_ch: model it now so expectations stay in order
      if (in_ch.valid && in_ch.ready) fused_q.push_back(fuse_reading(offered));
      if (!in_ch.valid || in_ch.ready) begin
        if (reading_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered = reading_q.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.first_ok    <= offered.first_ok;
          in_ch.first_temp  <= offered.first_temp;
          in_ch.first_hum   <= offered.first_hum;
          in_ch.second_ok   <= offered.second_ok;
          in_ch.second_temp <= offered.second_temp;
          in_ch.second_hum  <= offered.second_hum;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random ready, forced low while a long hold-off runs
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_served != stall_reqs) begin
      stall_served <= stall_served + 1;
      stall_left   <= 300;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every result transfer is matched against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (fused_q.size() == 0) begin
        $error("result transfer with no reading outstanding");
        err_cnt++;
      end else begin
        mon_want = fused_q.pop_front();
        check_field("fused_temp",  mon_want.fused_temp,  out_ch.fused_temp);
        check_field("temp_valid",  mon_want.temp_valid,  out_ch.temp_valid);
        check_field("temp_status", mon_want.temp_status, out_ch.temp_status);
        check_field("fused_hum",   mon_want.fused_hum,   out_ch.fused_hum);
        check_field("hum_valid",   mon_want.hum_valid,   out_ch.hum_valid);
        check_field("hum_status",  mon_want.hum_status,  out_ch.hum_status);
        check_field("heat_on",     mon_want.heat_on,     out_ch.heat_on);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [TEMP_IN_W-1:0] clamp_temp(int v);
    if (v > 1023)  v = 1023;
    if (v < -1024) v = -1024;
    return v[TEMP_IN_W-1:0];
  endfunction

  function automatic logic [HUM_W-1:0] clamp_hum(int v);
    if (v > 1023) v = 1023;
    if (v < 0)    v = 0;
    return v[HUM_W-1:0];
  endfunction

  function automatic void queue_reading(logic ok1, int t1, int h1, logic ok2, int t2, int h2);
    sample_t s;
    s.first_ok    = ok1;
    s.first_temp  = t1[TEMP_IN_W-1:0];
    s.first_hum   = h1[HUM_W-1:0];
    s.second_ok   = ok2;
    s.second_temp = t2[TEMP_IN_W-1:0];
    s.second_hum  = h2[HUM_W-1:0];
    reading_q.push_back(s);
  endfunction

  // mostly close pairs so gap limits get exercised, some raw full-range values
  function automatic sample_t random_reading();
    sample_t                     s;
    logic signed [TEMP_IN_W-1:0] tmp;
    int                          base, spread;
    s.first_ok  = ($urandom_range(99) < 85);
    s.second_ok = ($urandom_range(99) < 85);
    case ($urandom_range(7))
      0: begin
        s.first_temp  = 11'($urandom_range(2047));
        s.second_temp = 11'($urandom_range(2047));
      end
      1: begin
        s.first_temp  = clamp_temp(-int'($urandom_range(1, 400)));
        s.second_temp = clamp_temp($urandom_range(0, 800));
      end
      default: begin
        base   = $urandom_range(0, 800);
        spread = ($urandom_range(3) == 0) ? 250 : 60;
        s.first_temp  = clamp_temp(base);
        s.second_temp = clamp_temp(base + int'($urandom_range(0, 2 * spread)) - spread);
      end
    endcase
    if ($urandom_range(1) == 1) begin
      tmp           = s.first_temp;
      s.first_temp  = s.second_temp;
      s.second_temp = tmp;
    end
    if ($urandom_range(4) == 0) begin
      s.first_hum  = 10'($urandom_range(1023));
      s.second_hum = 10'($urandom_range(1023));
    end else begin
      base         = $urandom_range(0, 1000);
      s.first_hum  = clamp_hum(base);
      s.second_hum = clamp_hum(base + int'($urandom_range(0, 300)) - 150);
    end
    return s;
  endfunction

  // neither temperature usable: failed read, negative value, or both
  function automatic sample_t double_fail_reading();
    sample_t s;
    int      how;
    s   = random_reading();
    how = $urandom_range(2);
    if (how != 1) s.first_ok = 1'b0;
    if (how != 0) s.first_temp = clamp_temp(-int'($urandom_range(1, 1024)));
    how = $urandom_range(2);
    if (how != 1) s.second_ok = 1'b0;
    if (how != 0) s.second_temp = clamp_temp(-int'($urandom_range(1, 1024)));
    return s;
  endfunction

  // random readings with occasional bursts of double failures
  task automatic run_random(int n);
    int k, burst;
    k = 0;
    while (k < n) begin
      if ($urandom_range(99) < 6) begin
        burst = $urandom_range(1, 6);
        repeat (burst) reading_q.push_back(double_fail_reading());
        k += burst;
      end else begin
        reading_q.push_back(random_reading());
        k++;
      end
    end
  endtask

  // all readings sent and every result received
  task automatic wait_idle();
    do @(negedge clk);
    while (reading_q.size() != 0 || in_ch.valid || fused_q.size() != 0);
  endtask

  // APB write, then read the register back; ends on a falling edge
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    logic [31:0] want, got;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    // write lands at this edge; psel stays high into the read setup
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    unique case (idx)
      REG_TARGET_TEMP:    tgt      = val[TARGET_W-1:0];
      REG_FAIL_LIMIT:     lim_fail = val[FAIL_W-1:0];
      REG_TEMP_GAP_LIMIT: lim_tgap = val[TGAP_W-1:0];
      REG_HUM_GAP_LIMIT:  lim_hgap = val[HGAP_W-1:0];
    endcase
    case (idx)
      REG_TARGET_TEMP:    want = 32'(tgt);
      REG_FAIL_LIMIT:     want = 32'(lim_fail);
      REG_TEMP_GAP_LIMIT: want = 32'(lim_tgap);
      default:            want = 32'(lim_hgap);
    endcase
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    got = cfg_prdata;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    check_field("register readback", want, got);
  endtask

  task automatic write_all(logic [31:0] t, logic [31:0] f, logic [31:0] tg, logic [31:0] hg);
    write_reg(REG_TARGET_TEMP, t);
    write_reg(REG_FAIL_LIMIT, f);
    write_reg(REG_TEMP_GAP_LIMIT, tg);
    write_reg(REG_HUM_GAP_LIMIT, hg);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    in_ch.valid       = 1'b0;
    in_ch.first_ok    = 1'b0;
    in_ch.first_temp  = '0;
    in_ch.first_hum   = '0;
    in_ch.second_ok   = 1'b0;
    in_ch.second_temp = '0;
    in_ch.second_hum  = '0;
    out_ch.ready      = 1'b0;

    // register and state values after reset
    tgt      = TARGET_RST;
    lim_fail = FAIL_LIM_RST;
    lim_tgap = TGAP_RST;
    lim_hgap = HGAP_RST;
    held     = '0;
    held_ok  = 1'b1;
    fail_cnt = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed readings under reset settings, sender idles lightly
    tx_idle_pct = 12;
    rx_idle_pct = 64;
    queue_reading(1, 250, 500, 1, 250, 500);
    queue_reading(1, 800, 1000, 1, 800, 1000);
    queue_reading(1, 0, 0, 1, 0, 0);
    queue_reading(1, 1023, 1023, 1, 1023, 1023);
    queue_reading(1, -400, 0, 1, -400, 0);          // both negative, both reads ok
    queue_reading(1, -1024, 1023, 1, 1023, 0);      // raw extremes, big gaps
    queue_reading(0, 300, 400, 1, 310, 420);        // first read fails
    queue_reading(1, 300, 400, 0, 310, 420);        // second read fails
    queue_reading(0, 300, 400, 0, 310, 420);        // both fail, humidity invalid
    queue_reading(1, -5, 450, 1, 355, 460);         // one negative temperature
    queue_reading(1, 290, 500, 1, 250, 500);        // gap just over limit
    queue_reading(1, 289, 500, 1, 250, 500);        // gap truncates to limit
    queue_reading(1, -35, 500, 1, 5, 500);          // negative side of the gap
    queue_reading(1, -39, 500, 1, 0, 500);          // truncates toward zero
    queue_reading(1, 300, 610, 1, 300, 500);        // humidity disagrees
    queue_reading(1, 300, 609, 1, 300, 500);
    queue_reading(1, 359, 500, 1, 360, 500);        // heating just below target
    queue_reading(1, 360, 500, 1, 360, 500);        // at target, heating off
    queue_reading(1, 361, 501, 1, 360, 500);
    queue_reading(1, 0, 1023, 1, 1023, 0);
    wait_idle();

    // short fail limit: held temperature goes invalid on the third double failure
    write_all(40, 2, 0, 0);
    queue_reading(0, 300, 400, 0, 300, 400);
    queue_reading(1, -1, 400, 0, 300, 400);
    queue_reading(1, -100, 400, 1, -200, 410);
    queue_reading(0, -1024, 0, 1, -1, 1023);
    queue_reading(1, 400, 400, 1, 399, 400);
    run_random(30);
    wait_idle();

    // receiver idles lightly, sender often; one full pause in the middle
    tx_idle_pct = 64;
    rx_idle_pct = 12;
    write_all(0, 0, 20, 100);
    run_random(25);
    wait_idle();
    run_random(25);
    wait_idle();

    // no idling; register values at the top of their widths
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_all(32'hFFFF_FFFF, 255, 31, 127);
    // long receiver hold-off while readings keep coming
    stall_reqs++;
    run_random(30);
    wait_idle();

    // saturate the failure count; a limit of 255 keeps the held value valid
    queue_reading(1, 500, 500, 1, 510, 500);
    repeat (258) reading_q.push_back(double_fail_reading());
    wait_idle();
    write_reg(REG_FAIL_LIMIT, 254);
    queue_reading(0, 500, 500, 0, 500, 500);
    queue_reading(1, 500, 500, 1, 510, 500);
    wait_idle();

    // random settings within range
    write_all($urandom_range(0, 40), $urandom_range(0, 12), $urandom_range(0, 20),
              $urandom_range(0, 100));
    run_random(60);
    wait_idle();

    // let any stray result show up before deciding
    repeat (10) @(posedge clk);
    if (fused_q.size() != 0) begin
      $error("%0d results never arrived", fused_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
